### design/simplex_noise_2d_defines.svh
// Assertion macros shared by the simplex noise design.
`ifndef SIMPLEX_NOISE_2D_DEFINES_SVH
`define SIMPLEX_NOISE_2D_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SNZ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define SNZ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/snz_pkg.sv
`default_nettype none
package snz_pkg;

    localparam int COORD_FRAC_DEF = 16;
    localparam int OUT_FRAC_DEF   = 14;
    localparam int INT_FRAC       = 24;
    localparam int COORD_W        = 32;
    localparam int OUT_W          = 16;
    localparam int PERM_AW        = 8;
    localparam int PERM_W         = 8;
    localparam int PERM_DEPTH     = 256;
    localparam int FRAC_W         = 24;
    localparam int OFS_W          = 28;
    localparam int T_W            = 34;
    localparam int G_W            = 30;
    localparam int C_W            = 31;
    localparam int SUM_W          = 33;
    localparam int NUM_CORNERS    = 3;

    localparam logic [30:0] SKEW_Q32   = 31'd1572067139;
    localparam logic [29:0] UNSKEW_Q32 = 30'd907633386;
    localparam logic [21:0] UNSKEW_Q24 = 22'd3545443;
    localparam logic [24:0] ONE_Q24    = 25'd16777216;
    localparam logic [23:0] HALF_Q24   = 24'd8388608;
    localparam logic [6:0]  SCALE      = 7'd70;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef struct packed {
        logic signed [OFS_W-1:0]  dx;
        logic signed [OFS_W-1:0]  dy;
        logic        [PERM_W-1:0] hash;
    } snz_corner_t;

endpackage
`default_nettype wire

### design/snz_ram.sv
`default_nettype none
module snz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### design/snz_cell.sv
`default_nettype none
module snz_cell #(
    parameter int COORD_FRAC_BITS = snz_pkg::COORD_FRAC_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  ce,
    input  wire logic                                  in_valid,
    input  wire logic                                  in_cmd,
    input  wire logic [snz_pkg::PERM_AW-1:0]           in_index,
    input  wire logic [snz_pkg::PERM_W-1:0]            in_value,
    input  wire logic [snz_pkg::COORD_W-1:0]           in_x,
    input  wire logic [snz_pkg::COORD_W-1:0]           in_y,
    output logic                                       out_valid,
    output snz_pkg::snz_corner_t [snz_pkg::NUM_CORNERS-1:0] out_corner
);
    import snz_pkg::*;

    localparam int CF = COORD_FRAC_BITS;

    logic                      v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                      cmd1_reg, cmd2_reg, cmd3_reg;
    logic [PERM_AW-1:0]        idx1_reg, idx2_reg, idx3_reg;
    logic [PERM_W-1:0]         val1_reg, val2_reg, val3_reg;
    logic signed [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [COORD_W:0]   s2_reg;
    logic [PERM_AW-1:0]        ci3_reg;
    logic [FRAC_W-1:0]         fx3_reg, fy3_reg, fx4_reg, fy4_reg;
    logic [22:0]               k4_reg;
    logic                      i1_4_reg;
    snz_corner_t [NUM_CORNERS-1:0] corner5_reg;

    logic signed [COORD_W:0]     sxy;
    logic signed [31:0]          skew_s;
    logic signed [2*COORD_W:0]   skew_prod;
    logic signed [COORD_W+1:0]   xs, ys;
    logic [PERM_AW-1:0]          cj_next;
    logic [FRAC_W-1:0]           fx_next, fy_next;
    logic                        ld2_we, ld3_we;
    logic [PERM_W-1:0]           inner0, inner1, mid_inner;
    logic                        i1_next;
    logic [FRAC_W:0]             fsum;
    logic [54:0]                 k_prod;
    logic [PERM_AW-1:0]          oaddr0, oaddr1, oaddr2;
    logic [PERM_W-1:0]           hash0, hash1, hash2;
    logic signed [OFS_W-1:0]     x0, y0;
    logic signed [OFS_W-1:0]     one_s, g1_s, g2_s;

    assign sxy       = {x1_reg[COORD_W-1], x1_reg} + {y1_reg[COORD_W-1], y1_reg};
    assign skew_s    = $signed({1'b0, SKEW_Q32});
    assign skew_prod = sxy * skew_s;

    assign xs      = {{2{x2_reg[COORD_W-1]}}, x2_reg} + {s2_reg[COORD_W], s2_reg};
    assign ys      = {{2{y2_reg[COORD_W-1]}}, y2_reg} + {s2_reg[COORD_W], s2_reg};
    assign cj_next = ys[CF+PERM_AW-1:CF];
    assign fx_next = FRAC_W'(xs[CF-1:0]) << (INT_FRAC - CF);
    assign fy_next = FRAC_W'(ys[CF-1:0]) << (INT_FRAC - CF);
    assign ld2_we  = ce && v2_reg && (cmd2_reg == CMD_LOAD);
    assign ld3_we  = ce && v3_reg && (cmd3_reg == CMD_LOAD);

    assign i1_next   = fx3_reg > fy3_reg;
    assign mid_inner = i1_next ? inner0 : inner1;
    assign oaddr0    = ci3_reg + inner0;
    assign oaddr1    = ci3_reg + PERM_AW'(i1_next) + mid_inner;
    assign oaddr2    = ci3_reg + PERM_AW'(1) + inner1;
    assign fsum      = {1'b0, fx3_reg} + {1'b0, fy3_reg};
    assign k_prod    = 55'(fsum) * 55'(UNSKEW_Q32);

    assign x0    = $signed(OFS_W'(fx4_reg)) - $signed(OFS_W'(k4_reg));
    assign y0    = $signed(OFS_W'(fy4_reg)) - $signed(OFS_W'(k4_reg));
    assign one_s = $signed(OFS_W'(ONE_Q24));
    assign g1_s  = $signed(OFS_W'(UNSKEW_Q24));
    assign g2_s  = $signed(OFS_W'({UNSKEW_Q24, 1'b0}));

    snz_ram #(.WIDTH(PERM_W), .DEPTH(PERM_DEPTH)) u_inner0 (
        .aclk(aclk), .we(ld2_we), .waddr(idx2_reg), .wdata(val2_reg),
        .re(ce), .raddr(cj_next), .rdata(inner0)
    );
    snz_ram #(.WIDTH(PERM_W), .DEPTH(PERM_DEPTH)) u_inner1 (
        .aclk(aclk), .we(ld2_we), .waddr(idx2_reg), .wdata(val2_reg),
        .re(ce), .raddr(cj_next + PERM_AW'(1)), .rdata(inner1)
    );
    snz_ram #(.WIDTH(PERM_W), .DEPTH(PERM_DEPTH)) u_outer0 (
        .aclk(aclk), .we(ld3_we), .waddr(idx3_reg), .wdata(val3_reg),
        .re(ce), .raddr(oaddr0), .rdata(hash0)
    );
    snz_ram #(.WIDTH(PERM_W), .DEPTH(PERM_DEPTH)) u_outer1 (
        .aclk(aclk), .we(ld3_we), .waddr(idx3_reg), .wdata(val3_reg),
        .re(ce), .raddr(oaddr1), .rdata(hash1)
    );
    snz_ram #(.WIDTH(PERM_W), .DEPTH(PERM_DEPTH)) u_outer2 (
        .aclk(aclk), .we(ld3_we), .waddr(idx3_reg), .wdata(val3_reg),
        .re(ce), .raddr(oaddr2), .rdata(hash2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg && (cmd3_reg == CMD_EVAL);
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cmd1_reg <= in_cmd;
            idx1_reg <= in_index;
            val1_reg <= in_value;
            x1_reg   <= in_x;
            y1_reg   <= in_y;

            cmd2_reg <= cmd1_reg;
            idx2_reg <= idx1_reg;
            val2_reg <= val1_reg;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            s2_reg   <= skew_prod[2*COORD_W:COORD_W];

            cmd3_reg <= cmd2_reg;
            idx3_reg <= idx2_reg;
            val3_reg <= val2_reg;
            ci3_reg  <= xs[CF+PERM_AW-1:CF];
            fx3_reg  <= fx_next;
            fy3_reg  <= fy_next;

            fx4_reg  <= fx3_reg;
            fy4_reg  <= fy3_reg;
            k4_reg   <= k_prod[54:32];
            i1_4_reg <= i1_next;

            corner5_reg[0].dx   <= x0;
            corner5_reg[0].dy   <= y0;
            corner5_reg[0].hash <= hash0;
            corner5_reg[1].dx   <= (i1_4_reg ? x0 - one_s : x0) + g1_s;
            corner5_reg[1].dy   <= (i1_4_reg ? y0 : y0 - one_s) + g1_s;
            corner5_reg[1].hash <= hash1;
            corner5_reg[2].dx   <= x0 - one_s + g2_s;
            corner5_reg[2].dy   <= y0 - one_s + g2_s;
            corner5_reg[2].hash <= hash2;
        end
    end

    assign out_valid  = v5_reg;
    assign out_corner = corner5_reg;

endmodule
`default_nettype wire

### design/snz_corner.sv
`default_nettype none
module snz_corner (
    input  wire logic                         aclk,
    input  wire logic                         ce,
    input  wire snz_pkg::snz_corner_t         cin,
    output logic signed [snz_pkg::C_W-1:0]    contrib
);
    import snz_pkg::*;

    logic signed [T_W-1:0]     t6_reg;
    logic signed [G_W-1:0]     g6_reg, g7_reg, g8_reg;
    logic [FRAC_W-1:0]         t2_7_reg, t4_8_reg;
    logic signed [C_W-1:0]     c9_reg;

    logic signed [2*OFS_W-1:0] sqx, sqy;
    logic signed [T_W-1:0]     t_next;
    logic signed [G_W-1:0]     u, v, gu, gv;
    logic [FRAC_W-1:0]         tp;
    logic [2*FRAC_W-1:0]       t2_prod, t4_prod;
    logic signed [FRAC_W+G_W:0] g_prod;

    assign sqx    = cin.dx * cin.dx;
    assign sqy    = cin.dy * cin.dy;
    assign t_next = $signed(T_W'(HALF_Q24))
                  - $signed(T_W'(sqx[2*OFS_W-1:INT_FRAC]))
                  - $signed(T_W'(sqy[2*OFS_W-1:INT_FRAC]));

    assign u  = cin.hash[2] ? G_W'(cin.dy) : G_W'(cin.dx);
    assign v  = cin.hash[2] ? G_W'(cin.dx) : G_W'(cin.dy);
    assign gu = cin.hash[0] ? -u : u;
    assign gv = cin.hash[1] ? -(v <<< 1) : (v <<< 1);

    assign tp      = t6_reg[T_W-1] ? '0 : t6_reg[FRAC_W-1:0];
    assign t2_prod = tp * tp;
    assign t4_prod = t2_7_reg * t2_7_reg;
    assign g_prod  = $signed({1'b0, t4_8_reg}) * g8_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            t6_reg   <= t_next;
            g6_reg   <= gu + gv;
            t2_7_reg <= t2_prod[2*FRAC_W-1:INT_FRAC];
            g7_reg   <= g6_reg;
            t4_8_reg <= t4_prod[2*FRAC_W-1:INT_FRAC];
            g8_reg   <= g7_reg;
            c9_reg   <= C_W'(g_prod >>> INT_FRAC);
        end
    end

    assign contrib = c9_reg;

endmodule
`default_nettype wire

### design/simplex_noise_2d.sv
// 2D simplex noise evaluator.
// Input channel s_*: one word per item. s_tuser is the command: low loads
// one permutation table byte, high evaluates noise at (coord_x, coord_y).
// Load words give no result; evaluate words give one m_* word holding
// the saturated noise value.
// Every table entry an evaluation reaches must be loaded first; loads
// take effect in order with the evaluations around them.
// Throughput: one word per cycle unless the receiver stalls; every stage
// is fully pipelined, the three corners run in parallel units and the
// table is replicated in five single-read RAMs.
// Reset clears all valid bits; the table contents stay undefined.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
`default_nettype none
module simplex_noise_2d #(
    parameter int COORD_FRAC_BITS = snz_pkg::COORD_FRAC_DEF,
    parameter int OUT_FRAC_BITS   = snz_pkg::OUT_FRAC_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // table_index[7:0], table_value[15:8], coord_x[47:16], coord_y[79:48]
    input  wire logic [79:0] s_tdata,
    // cmd[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // noise_value[15:0]
    output logic [15:0]      m_tdata
);
    import snz_pkg::*;

    localparam int OUT_SHIFT = INT_FRAC - OUT_FRAC_BITS;

    logic                                ce;
    logic                                cell_valid;
    snz_corner_t [NUM_CORNERS-1:0]       corner;
    logic signed [C_W-1:0]               contrib [NUM_CORNERS];
    logic                                v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;
    logic signed [SUM_W-1:0]             sum10_reg;
    logic                                m_tvalid_reg;
    logic [OUT_W-1:0]                    m_tdata_reg;
    logic signed [SUM_W+6:0]             scaled, shifted;
    logic [OUT_W-1:0]                    sat;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    snz_cell #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_cell (
        .aclk(aclk),
        .aresetn(aresetn),
        .ce(ce),
        .in_valid(s_tvalid),
        .in_cmd(s_tuser),
        .in_index(s_tdata[7:0]),
        .in_value(s_tdata[15:8]),
        .in_x(s_tdata[47:16]),
        .in_y(s_tdata[79:48]),
        .out_valid(cell_valid),
        .out_corner(corner)
    );

    for (genvar gi = 0; gi < NUM_CORNERS; gi++) begin : g_corner
        snz_corner u_corner (
            .aclk(aclk),
            .ce(ce),
            .cin(corner[gi]),
            .contrib(contrib[gi])
        );
    end

    assign scaled  = (SUM_W+7)'(sum10_reg) * $signed({1'b0, SCALE});
    assign shifted = scaled >>> OUT_SHIFT;

    always_comb begin
        if (shifted > (SUM_W+7)'(32767)) begin
            sat = 16'h7fff;
        end else if (shifted < -(SUM_W+7)'(32768)) begin
            sat = 16'h8000;
        end else begin
            sat = shifted[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            v8_reg       <= 1'b0;
            v9_reg       <= 1'b0;
            v10_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            v6_reg       <= cell_valid;
            v7_reg       <= v6_reg;
            v8_reg       <= v7_reg;
            v9_reg       <= v8_reg;
            v10_reg      <= v9_reg;
            m_tvalid_reg <= v10_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sum10_reg   <= SUM_W'(contrib[0]) + SUM_W'(contrib[1]) + SUM_W'(contrib[2]);
            m_tdata_reg <= sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "simplex_noise_2d_defines.svh"

    `SNZ_ASSERT_SAME(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready), "ready mismatch")
    `SNZ_ASSERT_NEXT(a_emit, v10_reg && s_tready, m_tvalid, "finished word not emitted")
    `SNZ_ASSERT_NEXT(a_freeze, !s_tready, $stable(v10_reg) && $stable(sum10_reg), "stall moved")

endmodule
`default_nettype wire

### tb/simplex_noise_2d_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module simplex_noise_2d_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    output int               fail_count,
    output int               pending_count,
    output int               noise_count
);
    import snz_pkg::*;

    localparam int CFB = COORD_FRAC_DEF;
    localparam int OFB = OUT_FRAC_DEF;
    localparam longint ONE  = 64'sd1 << INT_FRAC;
    localparam longint HALF = 64'sd1 << (INT_FRAC - 1);

    logic [7:0]        perm_copy [256];
    logic signed [15:0] noise_fifo [$];

    function automatic longint floor_sh(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic [7:0] hash_at(longint a, longint b);
        logic [7:0] inner;
        inner = perm_copy[b[7:0]];
        return perm_copy[8'(a[7:0] + inner)];
    endfunction

    function automatic longint grad_dot(logic [7:0] hash, longint x, longint y);
        logic [2:0] h;
        longint u, v;
        h = hash[2:0];
        u = (h < 4) ? x : y;
        v = (h < 4) ? y : x;
        return (h[0] ? -u : u) + (h[1] ? -2 * v : 2 * v);
    endfunction

    function automatic longint corner_term(longint dx, longint dy, logic [7:0] hash);
        longint t;
        t = HALF - ((dx * dx) >>> INT_FRAC) - ((dy * dy) >>> INT_FRAC);
        if (t < 0) return 0;
        t = (t * t) >>> INT_FRAC;
        t = (t * t) >>> INT_FRAC;
        return floor_sh(t * grad_dot(hash, dx, dy), INT_FRAC);
    endfunction

    function automatic logic signed [15:0] noise_at(logic [31:0] cx, logic [31:0] cy);
        longint x, y, s, xs, ys, ci, cj, fx, fy, k, x0, y0, i1, j1, sum, r, g;
        x = longint'(signed'(cx));
        y = longint'(signed'(cy));
        s = floor_sh((x + y) * longint'(SKEW_Q32), 32);
        xs = x + s;
        ys = y + s;
        ci = floor_sh(xs, CFB);
        cj = floor_sh(ys, CFB);
        fx = (xs & ((64'sd1 << CFB) - 1)) << (INT_FRAC - CFB);
        fy = (ys & ((64'sd1 << CFB) - 1)) << (INT_FRAC - CFB);
        k = ((fx + fy) * longint'(UNSKEW_Q32)) >>> 32;
        x0 = fx - k;
        y0 = fy - k;
        if (x0 > y0) begin
            i1 = 1; j1 = 0;
        end else begin
            i1 = 0; j1 = 1;
        end
        g = longint'(UNSKEW_Q24);
        sum = corner_term(x0, y0, hash_at(ci, cj));
        sum += corner_term(x0 - i1 * ONE + g, y0 - j1 * ONE + g, hash_at(ci + i1, cj + j1));
        sum += corner_term(x0 - ONE + 2 * g, y0 - ONE + 2 * g, hash_at(ci + 1, cj + 1));
        r = floor_sh(sum * 70, INT_FRAC - OFB);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    assign pending_count = noise_fifo.size();

    always @(posedge aclk) begin
        logic signed [15:0] want;
        if (!aresetn) begin
            fail_count <= 0;
            noise_count <= 0;
            noise_fifo.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                noise_count <= noise_count + 1;
                if (noise_fifo.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected noise word %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = noise_fifo.pop_front();
                    if (m_tdata !== want) begin
                        if (fail_count < 10)
                            $display("noise mismatch: expected %0d got %0d",
                                     want, $signed(m_tdata));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD)
                    perm_copy[s_tdata[7:0]] = s_tdata[15:8];
                else
                    noise_fifo.push_back(noise_at(s_tdata[47:16], s_tdata[79:48]));
            end
        end
    end
endmodule
`default_nettype wire

### tb/simplex_noise_2d_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module simplex_noise_2d_tb;
    import snz_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    int          fail_count, pending_count, noise_count;
    bit          calm = 0;
    int          load_count = 0, eval_count = 0;

    always #4 aclk = ~aclk;

    simplex_noise_2d DUT (.*);

    simplex_noise_2d_checker checker_i (.*);

    always @(posedge aclk) begin
        int gap;
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            m_tready <= 0;
            repeat (gap) @(posedge aclk);
        end
        m_tready <= 1;
    end

    task automatic send_word(logic cmd, logic [7:0] idx, logic [7:0] val,
                             logic [31:0] cx, logic [31:0] cy);
        int gap;
        if (!calm && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {cy, cx, val, idx};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_LOAD) load_count++;
        else eval_count++;
    endtask

    task automatic load_table(bit ident);
        for (int n = 0; n < 256; n++)
            send_word(CMD_LOAD, 8'(n), ident ? 8'(n) : 8'($urandom), $urandom, $urandom);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
            2: return {16'($urandom_range(0, 255) - 128), 16'h0};
            default: return 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
        endcase
    endfunction

    initial begin
        logic [31:0] edges [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0,
                                   32'h0001_0000, 32'hffff_ffff, 32'h0000_8000};
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        load_table(1);
        foreach (edges[a])
            for (int b = 0; b < 4; b++)
                send_word(CMD_EVAL, 8'($urandom), 8'($urandom), edges[a], edges[(a + b) % 6]);
        for (int p = 0; p < 3; p++) begin
            load_table(0);
            for (int n = 0; n < 200; n++) begin
                if (p == 2 && n == 80) calm = 1;
                if ($urandom_range(0, 19) == 0)
                    send_word(CMD_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom);
                else
                    send_word(CMD_EVAL, 8'($urandom), 8'($urandom), rand_coord(), rand_coord());
            end
        end
        s_tvalid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        $display("covered %0d table loads and %0d evaluations, %0d noise words checked",
                 load_count, eval_count, noise_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #4ms;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
